// ===== hdl/u16d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16d_pkg
// Shared types and constants for the UTF-16 byte decoder.
// ----------------------------------------------------------------------------
package u16d_pkg;

  localparam int CP_W    = 21;
  localparam int HELD_W  = 18;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic       OP_DATA  = 1'b0;
  localparam logic       OP_FLUSH = 1'b1;

  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_BE   = 2'd1;
  localparam logic [1:0] MODE_LE   = 2'd2;

  localparam logic       REG_MODE  = 1'b0;

  localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;
  localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
  localparam logic [5:0]  SUR_HIGH    = 6'b110110;
  localparam logic [5:0]  SUR_LOW     = 6'b110111;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

  typedef enum logic [1:0] {
    PH_FIRST     = 2'd0,
    PH_SECOND    = 2'd1,
    PH_HI_FIRST  = 2'd2,
    PH_HI_SECOND = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ORD_NONE = 2'd0,
    ORD_BE   = 2'd1,
    ORD_LE   = 2'd2
  } order_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad_input;
    logic            last_of_run;
  } res_t;

endpackage

// ===== hdl/utf16_byte_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_byte_decoder
// UTF-16 byte stream to Unicode code points with byte order mark detection.
// ----------------------------------------------------------------------------
// One byte request is taken per cycle. A byte completing a unit is decoded in
// the same cycle into the result register; a request yields zero, one or two
// results. A two-result request (high surrogate followed by a normal unit)
// parks its second result in a spare register; the input is held off until the
// spare result moves on, and while a result waits under out_stall. The first
// result of a request shows in the cycle after it is taken. Mode register at
// byte address 0: 0 auto (BOM), 1 big-endian, 2 little-endian, 3 as auto.
// ----------------------------------------------------------------------------
module utf16_byte_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [u16d_pkg::ADDR_W-1:0] paddr,
  input  logic [u16d_pkg::DATA_W-1:0] pwdata,
  output logic [u16d_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [7:0]                 in_data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [u16d_pkg::CP_W-1:0]  out_code_point,
  output logic                       out_bad_input,
  output logic                       out_last_of_run
);
  import u16d_pkg::*;

  logic [1:0]        mode_r;
  phase_t            phase_r, phase_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  order_t            order_r, order_nxt;

  res_t out_r, out_nxt, spare_r, spare_nxt;
  logic out_vld_r, out_vld_nxt, spare_vld_r, spare_vld_nxt;

  logic       acc, deq, cfg_wr;
  logic       le, autodet, hi, lo;
  logic [15:0] unit;
  logic [1:0]  nres;
  res_t        r0, r1;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[ADDR_W-1] == REG_MODE) ? {{(DATA_W-2){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_AUTO;
    end else if (cfg_wr && paddr[ADDR_W-1] == REG_MODE) begin
      mode_r <= pwdata[1:0];
    end
  end

  // handshake
  assign in_stall = spare_vld_r | (out_vld_r & out_stall);
  assign acc      = in_valid & ~in_stall;
  assign deq      = out_vld_r & ~out_stall;

  // decode
  always_comb begin
    le      = 1'b0;
    autodet = 1'b0;
    case (mode_r)
      MODE_BE: le = 1'b0;
      MODE_LE: le = 1'b1;
      default: begin
        le      = (order_r == ORD_LE);
        autodet = (order_r == ORD_NONE) && (phase_r == PH_SECOND);
      end
    endcase
    unit = le ? {in_data_byte, held_r[7:0]} : {held_r[7:0], in_data_byte};
    hi   = (unit[15:10] == SUR_HIGH);
    lo   = (unit[15:10] == SUR_LOW);
  end

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    order_nxt = order_r;
    nres      = 2'd0;
    r0        = '0;
    r1        = '0;
    if (in_op == OP_FLUSH) begin
      if (phase_r != PH_FIRST) begin
        nres         = 2'd1;
        r0.bad_input = 1'b1;
      end
      phase_nxt = PH_FIRST;
      held_nxt  = '0;
      order_nxt = ORD_NONE;
    end else if (phase_r == PH_FIRST || phase_r == PH_HI_FIRST) begin
      held_nxt  = {held_r[HELD_W-1:8], in_data_byte};
      phase_nxt = (phase_r == PH_FIRST) ? PH_SECOND : PH_HI_SECOND;
    end else if (autodet && unit == BOM_SWAPPED) begin
      order_nxt = ORD_LE;
      phase_nxt = PH_FIRST;
      held_nxt  = '0;
    end else if (autodet && unit == BOM_NATIVE) begin
      order_nxt = ORD_BE;
      phase_nxt = PH_FIRST;
      held_nxt  = '0;
    end else begin
      if (autodet) begin
        order_nxt = ORD_BE;
      end
      if (hi) begin
        held_nxt  = {unit[9:0], 8'h00};
        phase_nxt = PH_HI_FIRST;
        if (phase_r == PH_HI_SECOND) begin
          nres         = 2'd1;
          r0.bad_input = 1'b1;
        end
      end else begin
        phase_nxt = PH_FIRST;
        held_nxt  = '0;
        if (phase_r == PH_SECOND) begin
          nres = 2'd1;
          if (lo) begin
            r0.bad_input = 1'b1;
          end else begin
            r0.code_point = {5'd0, unit};
          end
        end else if (lo) begin
          nres          = 2'd1;
          r0.code_point = {1'b0, held_r[HELD_W-1:8], unit[9:0]} + SUPP_BASE;
        end else begin
          // pending high surrogate broken by a normal unit
          nres          = 2'd2;
          r0.bad_input  = 1'b1;
          r1.code_point = {5'd0, unit};
        end
      end
    end
    r0.last_of_run = (nres == 2'd1);
    r1.last_of_run = 1'b1;
  end

  // result register and spare
  always_comb begin
    out_nxt       = out_r;
    out_vld_nxt   = out_vld_r;
    spare_nxt     = spare_r;
    spare_vld_nxt = spare_vld_r;
    if (deq) begin
      out_nxt       = spare_r;
      out_vld_nxt   = spare_vld_r;
      spare_vld_nxt = 1'b0;
    end
    if (acc && nres != 2'd0) begin
      out_nxt       = r0;
      out_vld_nxt   = 1'b1;
      spare_nxt     = r1;
      spare_vld_nxt = (nres == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      held_r      <= '0;
      order_r     <= ORD_NONE;
      out_vld_r   <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
        order_r <= order_nxt;
      end
      out_vld_r   <= out_vld_nxt;
      spare_vld_r <= spare_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    spare_r <= spare_nxt;
  end

  assign out_valid       = out_vld_r;
  assign out_code_point  = out_r.code_point;
  assign out_bad_input   = out_r.bad_input;
  assign out_last_of_run = out_r.last_of_run;

  // checks
  a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    spare_vld_r |-> out_vld_r)
    else $error("spare result without head result");

  a_spare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    spare_vld_r |-> (spare_r.last_of_run && !out_r.last_of_run))
    else $error("spare result ordering broken");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_FLUSH) |=> (phase_r == PH_FIRST && order_r == ORD_NONE))
    else $error("flush did not clear state");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.bad_input) |-> (out_r.code_point == '0))
    else $error("bad result carries a code point");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks utf16_byte_decoder against a cycle-free decode model held here.
// Byte requests are sent with random gaps. Results are taken under random
// stall and compared in order with the predicted code points. The directed
// tests cover byte order marks, surrogate faults, truncation on flush and a
// mode change mid-pair. A random part then sends well-formed strings with
// errors mixed in, under all mode settings.
// ----------------------------------------------------------------------------
module testbench;
  import u16d_pkg::*;

  localparam logic [1:0] MODE_AUTO_ALT = 2'd3;
  localparam int RANDOM_ITEMS = 400;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid, in_stall, in_op;
  logic [7:0] in_data_byte;
  logic out_valid, out_stall;
  logic [CP_W-1:0] out_code_point;
  logic out_bad_input, out_last_of_run;

  // decoder model state
  logic [1:0] mode_reg;
  phase_t dec_phase;
  logic [HELD_W-1:0] dec_held;
  order_t dec_order;

  res_t expected_points[$];
  int errors = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  utf16_byte_decoder uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_point(out_code_point), .out_bad_input(out_bad_input),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("utf16_byte_decoder test failed");
    $finish;
  end

  // mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic res_t mk_result(input logic [CP_W-1:0] cp, input logic bad);
    res_t r;
    r.code_point = bad ? '0 : cp;
    r.bad_input = bad;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic decode_byte(input logic op, input logic [7:0] b);
    res_t found[$];
    order_t ord;
    logic sniff, skip;
    logic [15:0] word;
    logic [CP_W-1:0] cp;
    if (op == OP_FLUSH) begin
      if (dec_phase != PH_FIRST) found.push_back(mk_result('0, 1'b1));
      dec_phase = PH_FIRST;
      dec_held = '0;
      dec_order = ORD_NONE;
    end else if (dec_phase == PH_FIRST || dec_phase == PH_HI_FIRST) begin
      dec_held[7:0] = b;
      dec_phase = (dec_phase == PH_FIRST) ? PH_SECOND : PH_HI_SECOND;
    end else begin
      sniff = 1'b0;
      skip = 1'b0;
      if (mode_reg == MODE_BE) ord = ORD_BE;
      else if (mode_reg == MODE_LE) ord = ORD_LE;
      else if (dec_order == ORD_LE) ord = ORD_LE;
      else begin
        ord = ORD_BE;
        sniff = (dec_order == ORD_NONE) && (dec_phase == PH_SECOND);
      end
      word = (ord == ORD_LE) ? {b, dec_held[7:0]} : {dec_held[7:0], b};
      if (sniff) begin
        if (word == BOM_SWAPPED) begin
          dec_order = ORD_LE;
          skip = 1'b1;
        end else begin
          dec_order = ORD_BE;
          skip = (word == BOM_NATIVE);
        end
        if (skip) begin
          dec_phase = PH_FIRST;
          dec_held = '0;
        end
      end
      if (!skip && dec_phase == PH_SECOND) begin
        if (word[15:10] == SUR_HIGH) begin
          dec_held = {word[9:0], 8'h00};
          dec_phase = PH_HI_FIRST;
        end else begin
          dec_phase = PH_FIRST;
          dec_held = '0;
          if (word[15:10] == SUR_LOW) found.push_back(mk_result('0, 1'b1));
          else found.push_back(mk_result({5'd0, word}, 1'b0));
        end
      end else if (!skip) begin
        if (word[15:10] == SUR_HIGH) begin
          found.push_back(mk_result('0, 1'b1));
          dec_held = {word[9:0], 8'h00};
          dec_phase = PH_HI_FIRST;
        end else begin
          if (word[15:10] == SUR_LOW) begin
            cp = {1'b0, dec_held[17:8], word[9:0]} + SUPP_BASE;
            found.push_back(mk_result(cp, 1'b0));
          end else begin
            found.push_back(mk_result('0, 1'b1));
            found.push_back(mk_result({5'd0, word}, 1'b0));
          end
          dec_phase = PH_FIRST;
          dec_held = '0;
        end
      end
    end
    if (found.size() > 0) found[found.size() - 1].last_of_run = 1'b1;
    foreach (found[i]) expected_points.push_back(found[i]);
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result: code_point %h bad_input %b last_of_run %b",
               out_code_point, out_bad_input, out_last_of_run);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (out_code_point !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_code_point);
          errors++;
        end
        if (out_bad_input !== want.bad_input) begin
          $error("bad_input: expected %b, got %b", want.bad_input, out_bad_input);
          errors++;
        end
        if (out_last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, out_last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_len();
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  task automatic send_byte(input logic op, input logic [7:0] b);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 40) gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(op, b);
    items_sent++;
  endtask

  task automatic send_flush();
    send_byte(OP_FLUSH, 8'($urandom));
  endtask

  task automatic send_unit(input logic [15:0] word, input logic le);
    if (le) begin
      send_byte(OP_DATA, word[7:0]);
      send_byte(OP_DATA, word[15:8]);
    end else begin
      send_byte(OP_DATA, word[15:8]);
      send_byte(OP_DATA, word[7:0]);
    end
  endtask

  task automatic send_cp(input logic [CP_W-1:0] cp, input logic le);
    logic [CP_W-1:0] v;
    if (cp >= SUPP_BASE) begin
      v = cp - SUPP_BASE;
      send_unit({SUR_HIGH, v[19:10]}, le);
      send_unit({SUR_LOW, v[9:0]}, le);
    end else begin
      send_unit(cp[15:0], le);
    end
  endtask

  // let every queued result out, then wait out requests that yield none
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_MODE, 2'b00};
    pwdata <= {30'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_reg = m;
  endtask

  // reset mode is auto
  task automatic test_bom_detection();
    send_unit(BOM_SWAPPED, 1'b0);
    send_cp(SUPP_BASE, 1'b1);
    send_unit(16'hFFFF, 1'b1);
    send_flush();
    send_unit(BOM_NATIVE, 1'b0);
    send_cp('0, 1'b0);
    send_byte(OP_DATA, 8'h41);
    send_flush();
  endtask

  task automatic test_surrogate_faults();
    write_mode(MODE_BE);
    send_unit({SUR_LOW, 10'h000}, 1'b0);
    send_unit({SUR_HIGH, 10'h3FF}, 1'b0);
    send_unit({SUR_HIGH, 10'h000}, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_cp(21'h10FFFF, 1'b0);
    send_flush();
  endtask

  // high surrogate taken in BE mode, low half decoded after switch to auto
  task automatic test_mode_switch();
    send_unit({SUR_HIGH, 10'h2A5}, 1'b0);
    write_mode(MODE_AUTO);
    send_unit({SUR_LOW, 10'h15A}, 1'b0);
    send_unit({SUR_HIGH, 10'h001}, 1'b0);
    send_flush();
  endtask

  task automatic random_string(input logic [1:0] m);
    logic le;
    int n, pick;
    logic [15:0] word;
    le = (m == MODE_LE);
    if (m == MODE_AUTO || m == MODE_AUTO_ALT) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        send_unit(BOM_SWAPPED, 1'b0);
        le = 1'b1;
      end else if (pick == 1) begin
        send_unit(BOM_NATIVE, 1'b0);
      end
    end
    n = $urandom_range(1, 8);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        word = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'hD7FF))
                                    : 16'($urandom_range(16'hE000, 16'hFFFF));
        send_unit(word, le);
      end else if (pick < 75) begin
        send_cp(CP_W'($urandom_range(32'h10000, 32'h10FFFF)), le);
      end else if (pick < 80) begin
        send_unit({SUR_LOW, 10'($urandom)}, le);
      end else if (pick < 85) begin
        send_unit({SUR_HIGH, 10'($urandom)}, le);
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: send_cp('0, le);
          1: send_cp(21'h00FFFF, le);
          2: send_cp(SUPP_BASE, le);
          default: send_cp(21'h10FFFF, le);
        endcase
      end else if (pick < 97) begin
        send_byte(OP_DATA, 8'($urandom));
      end else begin
        send_flush();
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      send_flush();
    end else if (pick < 85) begin
      send_byte(OP_DATA, 8'($urandom));
      send_flush();
    end
  endtask

  task automatic test_random_streams();
    int start, round;
    logic [1:0] m;
    start = items_sent;
    round = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      case (round)
        0: m = MODE_AUTO_ALT;
        1: m = MODE_LE;
        2: m = MODE_BE;
        3: m = MODE_AUTO;
        default: m = 2'($urandom_range(0, 3));
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      write_mode(m);
      repeat ($urandom_range(1, 4)) random_string(m);
      round++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_op = OP_DATA;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    mode_reg = MODE_AUTO;
    dec_phase = PH_FIRST;
    dec_held = '0;
    dec_order = ORD_NONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bom_detection();
    test_surrogate_faults();
    test_mode_switch();
    test_random_streams();

    drain_results();
    if (errors == 0 && expected_points.size() == 0) begin
      $display("utf16_byte_decoder test passed");
    end else begin
      $display("utf16_byte_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/u16d_pkg.sv
hdl/utf16_byte_decoder.sv
tb/testbench.sv
